FILE: src/pnfb_pkg.sv
package pnfb_pkg;

   // Default screen geometry.
   localparam int DEF_SCREEN_WIDTH  = 320;
   localparam int DEF_SCREEN_HEIGHT = 240;

   // Command opcodes.
   localparam logic [2:0] OP_FILL  = 3'd0;
   localparam logic [2:0] OP_PUT   = 3'd1;
   localparam logic [2:0] OP_GET   = 3'd2;
   localparam logic [2:0] OP_HLINE = 3'd3;
   localparam logic [2:0] OP_VLINE = 3'd4;
   localparam logic [2:0] OP_BOX   = 3'd5;

   // Field widths of one command and one result.
   localparam int OPCODE_W = 3;
   localparam int XF_W     = 9;
   localparam int YF_W     = 8;
   localparam int COLOR_W  = 4;
   localparam int THICK_W  = 8;
   localparam int PIXEL_W  = 4;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_BITS = OPCODE_W + 2 * XF_W + 2 * YF_W + COLOR_W + THICK_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = 8;

   // Signed width of rectangle corner arithmetic; holds every corner and the
   // screen limits for any supported geometry.
   localparam int CRD_W = 12;

   // Box outline is drawn as four rectangles.
   localparam logic [1:0] LAST_SIDE = 2'd3;

endpackage

FILE: src/packed_nibble_framebuffer_draw_unit.sv
// Packed 4-bit frame store with drawing commands.
//
// Commands arrive on the req_ stream, one command per transfer, and every
// command gives exactly one result transfer on the rsp_ stream: the pixel
// read by a get pixel command (zero otherwise) and a flag that is set when
// addressed pixels lay off screen and were dropped. Opcodes 6 and 7 do nothing.
//
// The block works on one command at a time; req_tready is high only while
// it is idle. Drawing walks each rectangle pixel by pixel through one byte
// read-modify-write port: each pixel is read, then written back merged. A
// rectangle that is empty or wholly off screen is dropped after its setup
// and clamp steps without touching the store. A fill writes the whole store,
// one byte a cycle. The next command can be taken as soon as the result of
// the last one is in the output register.
//
// Reset clears the sequencer and the result valid flag; the frame store is
// not cleared and holds garbage until written. A finished result sits in an
// output register, so a stalled receiver does not block the next command
// from being accepted; the sequencer only waits at its end until the output
// register is free again.
module packed_nibble_framebuffer_draw_unit
   import pnfb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   // Command stream. tdata from bit 0 up: opcode[3], x_start[9], y_start[8],
   // x_end[9], y_end[8], color[4], thickness[8], zero fill[7].
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // Result stream. tdata from bit 0 up: pixel[4], clipped[1], zero fill[3].
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT + 1);
   localparam logic [AW-1:0] ROW_STEP   = AW'(ROW_BYTES);
   localparam logic [AW-1:0] LAST_BYTE  = AW'(STORE_BYTES - 1);
   localparam logic signed [CRD_W-1:0] X_MAX = CRD_W'(SCREEN_WIDTH - 1);
   localparam logic signed [CRD_W-1:0] Y_MAX = CRD_W'(SCREEN_HEIGHT - 1);
   localparam logic signed [CRD_W-1:0] ONE   = CRD_W'(1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_CLAMP = 3'd2;
   localparam logic [2:0] S_BASE  = 3'd3;
   localparam logic [2:0] S_RD    = 3'd4;
   localparam logic [2:0] S_WR    = 3'd5;
   localparam logic [2:0] S_FILL  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // Frame store: one byte per pixel pair, even x in the high nibble.
   logic [7:0] frame_mem [STORE_BYTES];

   logic [2:0]  state_ff, state_in;

   // Captured command.
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [XF_W-1:0]     xs_ff, xs_in, xe_ff, xe_in;
   logic [YF_W-1:0]     ys_ff, ys_in, ye_ff, ye_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic [THICK_W-1:0]  thick_ff, thick_in;

   // Current rectangle, raw and clamped, and the walk position.
   logic [1:0]              side_ff, side_in;
   logic signed [CRD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [XW-1:0]           x0c_ff, x0c_in, x1c_ff, x1c_in;
   logic [YW-1:0]           y0c_ff, y0c_in, y1c_ff, y1c_in;
   logic [XW-1:0]           cur_x_ff, cur_x_in;
   logic [YW-1:0]           cur_y_ff, cur_y_in;
   logic [AW-1:0]           row_base_ff, row_base_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           fill_ff, fill_in;
   logic [7:0]              rd_data_ff;

   // Result being built and the output register.
   logic               clip_ff, clip_in;
   logic [PIXEL_W-1:0] pix_ff, pix_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_clip_ff, rsp_clip_in;
   logic [PIXEL_W-1:0] rsp_pix_ff, rsp_pix_in;

   // Memory port controls.
   logic          mem_re;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // Signed views of the command fields.
   logic signed [CRD_W-1:0] sxs, sxe, sys, sye, st;

   // Clamp step results.
   logic                    empty;
   logic                    active;
   logic                    rect_clip;
   logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1;
   logic                    last_rect;
   logic                    out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_clip_ff, rsp_pix_ff};

   assign sxs = signed'(CRD_W'(xs_ff));
   assign sxe = signed'(CRD_W'(xe_ff));
   assign sys = signed'(CRD_W'(ys_ff));
   assign sye = signed'(CRD_W'(ye_ff));
   assign st  = signed'(CRD_W'(thick_ff));

   assign empty     = (x0_ff > x1_ff) || (y0_ff > y1_ff);
   assign rect_clip = !empty && ((x0_ff < 0) || (y0_ff < 0) || (x1_ff > X_MAX)
                                 || (y1_ff > Y_MAX));
   assign cx0       = (x0_ff < 0) ? '0 : x0_ff;
   assign cy0       = (y0_ff < 0) ? '0 : y0_ff;
   assign cx1       = (x1_ff > X_MAX) ? X_MAX : x1_ff;
   assign cy1       = (y1_ff > Y_MAX) ? Y_MAX : y1_ff;
   // A rectangle can still be empty after clamping when it lies wholly off screen.
   assign active    = !empty && (cx0 <= cx1) && (cy0 <= cy1);
   assign last_rect = (op_ff != OP_BOX) || (side_ff == LAST_SIDE);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      xs_in        = xs_ff;
      ys_in        = ys_ff;
      xe_in        = xe_ff;
      ye_in        = ye_ff;
      color_in     = color_ff;
      thick_in     = thick_ff;
      side_in      = side_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      x0c_in       = x0c_ff;
      x1c_in       = x1c_ff;
      y0c_in       = y0c_ff;
      y1c_in       = y1c_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      row_base_in  = row_base_ff;
      addr_in      = row_base_ff + AW'(cur_x_ff >> 1);
      fill_in      = fill_ff;
      clip_in      = clip_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_clip_in  = rsp_clip_ff;
      rsp_pix_in   = rsp_pix_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = cur_x_ff[0] ? {rd_data_ff[7:4], color_ff} : {color_ff, rd_data_ff[3:0]};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               xs_in    = req_tdata[11:3];
               ys_in    = req_tdata[19:12];
               xe_in    = req_tdata[28:20];
               ye_in    = req_tdata[36:29];
               color_in = req_tdata[40:37];
               thick_in = req_tdata[48:41];
               side_in  = '0;
               fill_in  = '0;
               clip_in  = 1'b0;
               pix_in   = '0;
               case (req_tdata[2:0])
                  OP_FILL:  state_in = S_FILL;
                  OP_PUT, OP_GET, OP_HLINE, OP_VLINE, OP_BOX: state_in = S_SETUP;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SETUP: begin
            // Single pixel by default; lines and box sides widen it.
            x0_in = sxs;
            x1_in = sxs;
            y0_in = sys;
            y1_in = sys;
            case (op_ff)
               OP_HLINE: begin
                  x1_in = sxe;
                  y1_in = sys + st - ONE;
               end
               OP_VLINE: begin
                  x1_in = sxs + st - ONE;
                  y1_in = sye;
               end
               OP_BOX: begin
                  case (side_ff)
                     2'd0: begin
                        x1_in = sxe;
                        y1_in = sys + st - ONE;
                     end
                     2'd1: begin
                        x1_in = sxs + st - ONE;
                        y1_in = sye;
                     end
                     2'd2: begin
                        x0_in = sxe - st + ONE;
                        x1_in = sxe;
                        y1_in = sye;
                     end
                     default: begin
                        x1_in = sxe;
                        y0_in = sye - st + ONE;
                        y1_in = sye;
                     end
                  endcase
               end
               default: begin
               end
            endcase
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            clip_in = clip_ff | rect_clip;
            x0c_in  = cx0[XW-1:0];
            x1c_in  = cx1[XW-1:0];
            y0c_in  = cy0[YW-1:0];
            y1c_in  = cy1[YW-1:0];
            if (active) begin
               state_in = S_BASE;
            end else if (last_rect) begin
               state_in = S_DONE;
            end else begin
               side_in  = side_ff + 2'd1;
               state_in = S_SETUP;
            end
         end
         S_BASE: begin
            row_base_in = AW'(y0c_ff) * ROW_STEP;
            cur_x_in    = x0c_ff;
            cur_y_in    = y0c_ff;
            state_in    = S_RD;
         end
         S_RD: begin
            mem_re   = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            if (op_ff == OP_GET) begin
               pix_in   = cur_x_ff[0] ? rd_data_ff[3:0] : rd_data_ff[7:4];
               state_in = S_DONE;
            end else begin
               mem_we = 1'b1;
               if (cur_x_ff != x1c_ff) begin
                  cur_x_in = cur_x_ff + 1'b1;
                  state_in = S_RD;
               end else if (cur_y_ff != y1c_ff) begin
                  cur_x_in    = x0c_ff;
                  cur_y_in    = cur_y_ff + 1'b1;
                  row_base_in = row_base_ff + ROW_STEP;
                  state_in    = S_RD;
               end else if (last_rect) begin
                  state_in = S_DONE;
               end else begin
                  side_in  = side_ff + 2'd1;
                  state_in = S_SETUP;
               end
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            mem_wdata = {color_ff, color_ff};
            if (fill_ff == LAST_BYTE) begin
               state_in = S_DONE;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_clip_in  = clip_ff;
               rsp_pix_in   = pix_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      xe_ff       <= xe_in;
      ye_ff       <= ye_in;
      color_ff    <= color_in;
      thick_ff    <= thick_in;
      side_ff     <= side_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      x0c_ff      <= x0c_in;
      x1c_ff      <= x1c_in;
      y0c_ff      <= y0c_in;
      y1c_ff      <= y1c_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      row_base_ff <= row_base_in;
      addr_ff     <= addr_in;
      fill_ff     <= fill_in;
      clip_ff     <= clip_in;
      pix_ff      <= pix_in;
      rsp_clip_ff <= rsp_clip_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   // Frame store port: one registered read, one write per cycle.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= frame_mem[addr_in];
      end
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
   end

`ifndef SYNTH
   // A command transfer always starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after a command transfer");

   // Pixel writes stay inside the frame store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR && op_ff != OP_GET) |-> (addr_ff <= LAST_BYTE))
      else $error("pixel write beyond the frame store");

   // The walk never runs past the clamped rectangle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (cur_x_ff <= x1c_ff && cur_y_ff <= y1c_ff
                              && cur_x_ff >= x0c_ff))
      else $error("rectangle walk out of bounds");

   // A result only appears when the sequencer finishes a command.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

FILE: dv/tb_packed_nibble_framebuffer_draw_unit.sv
module tb_packed_nibble_framebuffer_draw_unit;
   import pnfb_pkg::*;

   // Screen geometry of the instance under test and the size of its store.
   localparam int SCR_W       = DEF_SCREEN_WIDTH;
   localparam int SCR_H       = DEF_SCREEN_HEIGHT;
   localparam int ROW_BYTES   = (SCR_W + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCR_H;

   // Opcodes 6 and 7 are not assigned; the block must ignore them.
   localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 4000000;

   // One command, packed the way req_tdata carries it: opcode in the low bits.
   typedef struct packed {
      logic [THICK_W-1:0]  thickness;
      logic [COLOR_W-1:0]  color;
      logic [YF_W-1:0]     y_end;
      logic [XF_W-1:0]     x_end;
      logic [YF_W-1:0]     y_start;
      logic [XF_W-1:0]     x_start;
      logic [OPCODE_W-1:0] opcode;
   } draw_cmd_t;

   // One result, packed the way rsp_tdata carries it.
   typedef struct packed {
      logic               clipped;
      logic [PIXEL_W-1:0] pixel;
   } draw_result_t;

   // A row of the directed stimulus. Rows with known set carry a result that
   // is obvious by inspection; the others are checked against the predictor.
   typedef struct {
      draw_cmd_t    cmd;
      bit           known;
      draw_result_t rsp;
   } directed_row_t;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // Predicted contents of the frame store, two pixels per byte.
   logic [7:0]   frame_bytes [STORE_BYTES];
   draw_result_t pending_results [$];
   directed_row_t directed_rows [$];

   int          fail_count = 0;
   int unsigned cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          random_fills_left = 2;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   draw_result_t want;

   packed_nibble_framebuffer_draw_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit. A correct run needs a small fraction of this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Paints the inclusive rectangle with clipping at the screen edges. The
   // corners are signed, since box sides can start left of or above zero.
   // Returns 1 when a non-empty rectangle reaches off screen.
   function automatic bit paint_rect(int x0, int x1, int y0, int y1, logic [3:0] c);
      bit off;
      int idx;
      if (x0 > x1 || y0 > y1) return 1'b0;
      off = (x0 < 0 || y0 < 0 || x1 >= SCR_W || y1 >= SCR_H);
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > SCR_W - 1) x1 = SCR_W - 1;
      if (y1 > SCR_H - 1) y1 = SCR_H - 1;
      for (int y = y0; y <= y1; y++) begin
         for (int x = x0; x <= x1; x++) begin
            idx = (x >> 1) + y * ROW_BYTES;
            // The even pixel of a pair lives in the high nibble.
            if ((x & 1) != 0) frame_bytes[idx][3:0] = c;
            else frame_bytes[idx][7:4] = c;
         end
      end
      return off;
   endfunction

   // Applies one command to the predicted store and returns its result.
   function automatic draw_result_t apply_draw_command(draw_cmd_t cmd);
      draw_result_t r;
      int xs, ys, xe, ye, t, idx;
      r  = '0;
      xs = int'(cmd.x_start);
      ys = int'(cmd.y_start);
      xe = int'(cmd.x_end);
      ye = int'(cmd.y_end);
      t  = int'(cmd.thickness);
      case (cmd.opcode)
         OP_FILL: begin
            foreach (frame_bytes[i]) frame_bytes[i] = {cmd.color, cmd.color};
         end
         OP_PUT: begin
            r.clipped = paint_rect(xs, xs, ys, ys, cmd.color);
         end
         OP_GET: begin
            if (xs < SCR_W && ys < SCR_H) begin
               idx = (xs >> 1) + ys * ROW_BYTES;
               r.pixel = ((xs & 1) != 0) ? frame_bytes[idx][3:0] : frame_bytes[idx][7:4];
            end else begin
               r.clipped = 1'b1;
            end
         end
         OP_HLINE: begin
            r.clipped = paint_rect(xs, xe, ys, ys + t - 1, cmd.color);
         end
         OP_VLINE: begin
            r.clipped = paint_rect(xs, xs + t - 1, ys, ye, cmd.color);
         end
         OP_BOX: begin
            // Top, left, right and bottom sides, each clipped on its own.
            r.clipped = paint_rect(xs, xe, ys, ys + t - 1, cmd.color);
            r.clipped |= paint_rect(xs, xs + t - 1, ys, ye, cmd.color);
            r.clipped |= paint_rect(xe - t + 1, xe, ys, ye, cmd.color);
            r.clipped |= paint_rect(xs, xe, ye - t + 1, ye, cmd.color);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic directed_row_t dir_row(logic [OPCODE_W-1:0] op, int xs, int ys,
                                             int xe, int ye, int c, int t,
                                             bit known, int pix, bit clp);
      directed_row_t row;
      row.cmd.opcode    = op;
      row.cmd.x_start   = XF_W'(xs);
      row.cmd.y_start   = YF_W'(ys);
      row.cmd.x_end     = XF_W'(xe);
      row.cmd.y_end     = YF_W'(ye);
      row.cmd.color     = COLOR_W'(c);
      row.cmd.thickness = THICK_W'(t);
      row.known         = known;
      row.rsp.pixel     = PIXEL_W'(pix);
      row.rsp.clipped   = clp;
      return row;
   endfunction

   // Random command. Most lines and boxes are short and thin so that the run
   // stays short; a few span the whole screen thinly or are very thick but
   // narrow. Coordinates now and then leave the screen, and a few full fills
   // are mixed in.
   function automatic draw_cmd_t random_command();
      draw_cmd_t cmd;
      int pick, shape, xs, ys, xe, ye, t;
      pick = $urandom_range(0, 99);
      if (pick < 24) cmd.opcode = OP_PUT;
      else if (pick < 48) cmd.opcode = OP_GET;
      else if (pick < 64) cmd.opcode = OP_HLINE;
      else if (pick < 80) cmd.opcode = OP_VLINE;
      else if (pick < 96) cmd.opcode = OP_BOX;
      else if (pick < 98) cmd.opcode = OP_SPARE6;
      else cmd.opcode = OP_SPARE7;
      if (random_fills_left != 0 && $urandom_range(0, 149) == 0) begin
         cmd.opcode = OP_FILL;
         random_fills_left--;
      end
      xs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, SCR_W - 1);
      ys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, SCR_H - 1);
      shape = $urandom_range(0, 15);
      if (shape == 0) begin
         xe = $urandom_range(0, 511);
         ye = $urandom_range(0, 255);
         t  = $urandom_range(0, 2);
      end else if (shape == 1) begin
         xe = xs + $urandom_range(0, 3);
         ye = ys + $urandom_range(0, 3);
         t  = $urandom_range(6, 255);
      end else begin
         // Ending two short of the start gives the occasional empty range.
         xe = xs + $urandom_range(0, 24) - 2;
         ye = ys + $urandom_range(0, 24) - 2;
         t  = $urandom_range(0, 5);
      end
      cmd.x_start   = XF_W'(xs);
      cmd.y_start   = YF_W'(ys);
      cmd.x_end     = XF_W'(xe);
      cmd.y_end     = YF_W'(ye);
      cmd.color     = COLOR_W'($urandom_range(0, 15));
      cmd.thickness = THICK_W'(t);
      return cmd;
   endfunction

   // Offers one command, waits for its transfer and records what it must
   // produce. Valid stays high after the transfer; the next call either
   // replaces the data in the same step or drops valid for an idle gap.
   task automatic send_and_track(input draw_cmd_t cmd, input bit known,
                                 input draw_result_t known_rsp);
      draw_result_t model_rsp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(cmd);
      do @(posedge clock); while (!req_tready);
      model_rsp = apply_draw_command(cmd);
      pending_results.push_back(known ? known_rsp : model_rsp);
   endtask

   // Stops offering and waits until every outstanding result has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Result receiver. A change of hold_token starts a long hold-off, counted
   // here; otherwise ready follows the stall rate of the current phase.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Result checker: every result transfer is matched in order against the
   // oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no command outstanding: pixel %0d, clipped %0b",
                   rsp_tdata[PIXEL_W-1:0], rsp_tdata[PIXEL_W]);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[PIXEL_W-1:0] !== want.pixel) begin
               $error("pixel mismatch: expected %0d, got %0d",
                      want.pixel, rsp_tdata[PIXEL_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[PIXEL_W] !== want.clipped) begin
               $error("clipped mismatch: expected %0b, got %0b",
                      want.clipped, rsp_tdata[PIXEL_W]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      draw_cmd_t    cmd;
      draw_result_t none;
      none = '0;

      // The store is undefined after reset, so nothing reads an on-screen
      // pixel until the first full fill. Off-screen reads touch no store.
      directed_rows.push_back(dir_row(OP_GET, SCR_W, 0, 0, 0, 0, 0, 1, 0, 1));
      directed_rows.push_back(dir_row(OP_GET, 0, 255, 0, 0, 0, 0, 1, 0, 1));
      directed_rows.push_back(dir_row(OP_SPARE6, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_SPARE7, 511, 255, 511, 255, 15, 255, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_PUT, 511, 255, 0, 0, 15, 0, 1, 0, 1));
      directed_rows.push_back(dir_row(OP_FILL, 0, 0, 0, 0, 10, 0, 1, 0, 0));
      // From here on every pixel holds a known value.
      directed_rows.push_back(dir_row(OP_GET, 0, 0, 0, 0, 0, 0, 1, 10, 0));
      directed_rows.push_back(dir_row(OP_GET, SCR_W - 1, SCR_H - 1, 0, 0, 0, 0, 1, 10, 0));
      directed_rows.push_back(dir_row(OP_PUT, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_PUT, 1, 0, 0, 0, 15, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_GET, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_GET, 1, 0, 0, 0, 0, 0, 1, 15, 0));
      // A line 240 rows thick on the bottom row: only one row is on screen.
      directed_rows.push_back(dir_row(OP_HLINE, 0, SCR_H - 1, SCR_W - 1, 0, 3, 240, 1, 0, 1));
      // Empty ranges draw nothing and never clip; one vertical line runs off the right edge.
      directed_rows.push_back(dir_row(OP_HLINE, 10, 5, 5, 0, 7, 3, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_HLINE, 10, 5, 20, 0, 7, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_VLINE, SCR_W - 2, 0, 0, 20, 6, 4, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_VLINE, 5, 30, 0, 10, 6, 2, 1, 0, 0));
      // Box border around the whole screen, a box whose right side starts
      // left of column zero, an empty box and a box past the far corner.
      directed_rows.push_back(dir_row(OP_BOX, 0, 0, SCR_W - 1, SCR_H - 1, 5, 1, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_BOX, 2, 2, 5, 40, 9, 8, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_BOX, 100, 100, 120, 120, 4, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_BOX, 310, 230, 330, 250, 12, 3, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_GET, SCR_W - 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_GET, 0, SCR_H - 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(dir_row(OP_FILL, 0, 0, 0, 0, 15, 0, 1, 0, 0));
      directed_rows.push_back(dir_row(OP_GET, 160, 120, 0, 0, 0, 0, 1, 15, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_and_track(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].rsp);
      end
      // The sender pauses here until every result has come back.
      wait_for_results();

      // Random phases: no idling, sender mostly idle, receiver mostly
      // stalling, then light idling on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 83;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 83;
            end
            default: begin
               send_idle_pct = 18;
               stall_pct <= 18;
            end
         endcase
         if (phase == 0) begin
            // The receiver holds off for a long stretch while short pixel
            // commands keep coming, so the output register fills and the
            // block has to stall its input.
            hold_token <= hold_token + 1;
            repeat (12) begin
               cmd = random_command();
               cmd.opcode = ($urandom_range(0, 1) == 0) ? OP_PUT : OP_GET;
               send_and_track(cmd, 1'b0, none);
            end
         end
         repeat (ITEMS_PER_PHASE) send_and_track(random_command(), 1'b0, none);
         wait_for_results();
      end

      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
      end
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
